// ===== sv/ibfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfp_pkg
// Types and constants shared by the I-Bus frame parser core and its step logic.
// ----------------------------------------------------------------------------
package ibfp_pkg;

    // Result tag for each transfer
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SOURCE = 3'd1,
        KIND_LENGTH = 3'd2,
        KIND_DEST   = 3'd3,
        KIND_DATA   = 3'd4,
        KIND_GOOD   = 3'd5,
        KIND_BAD    = 3'd6,
        KIND_ABORT  = 3'd7
    } t_kind;

    // Input function codes
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // Minimum legal length byte (destination plus checksum)
    localparam logic [7:0] LEN_MIN   = 8'd2;
    // Header bytes ahead of the data: source, length, destination
    localparam logic [8:0] HDR_BYTES = 9'd3;

    // Frame positions of the header bytes
    localparam logic [8:0] POS_SOURCE = 9'd0;
    localparam logic [8:0] POS_LENGTH = 9'd1;
    localparam logic [8:0] POS_DEST   = 9'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] data_index;
        logic [7:0] frame_source;
        logic [7:0] frame_destination;
        logic [7:0] data_count;
        logic       restart_idle_timer;
    } t_out;

    // Parser state; position needs 9 bits since a 255 length frame ends at 256
    typedef struct packed {
        logic [8:0] position;
        logic [7:0] running_xor;
        logic [7:0] data_len;
        logic [7:0] held_source;
        logic [7:0] held_destination;
    } t_state;

endpackage

// ===== sv/ibfp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfp_step
// Per-item parser step: from the current state and one input item, the next
// state and the result item.
// ----------------------------------------------------------------------------
module ibfp_step
    import ibfp_pkg::*;
(
    input  t_state i_state,
    input  t_in    i_in,
    output t_state o_next,
    output t_out   o_res
);

    logic [8:0] data_pos;

    // Offset of the current byte within the data field
    assign data_pos = i_state.position - HDR_BYTES;

    always_comb begin
        o_next                   = i_state;
        o_res.kind               = KIND_NONE;
        o_res.value              = 8'd0;
        o_res.data_index         = 8'd0;
        o_res.frame_source       = i_state.held_source;
        o_res.frame_destination  = i_state.held_destination;
        o_res.data_count         = i_state.data_len;
        o_res.restart_idle_timer = 1'b0;

        if (i_in.func == FUNC_TIMEOUT) begin
            // Idle timeout: abort a partial frame, nothing when idle
            if (i_state.position != POS_SOURCE) begin
                o_res.kind = KIND_ABORT;
            end
            o_next = '0;
        end else begin
            o_res.restart_idle_timer = 1'b1;
            o_res.value              = i_in.rx_byte;
            if (i_state.position == POS_SOURCE) begin
                o_res.kind              = KIND_SOURCE;
                o_res.frame_source      = i_in.rx_byte;
                o_next.held_source      = i_in.rx_byte;
                o_next.running_xor      = i_state.running_xor ^ i_in.rx_byte;
                o_next.position         = POS_LENGTH;
            end else if (i_state.position == POS_LENGTH) begin
                if (i_in.rx_byte < LEN_MIN) begin
                    // Malformed length
                    o_res.kind = KIND_ABORT;
                    o_next     = '0;
                end else begin
                    o_res.kind         = KIND_LENGTH;
                    o_res.data_count   = i_in.rx_byte - LEN_MIN;
                    o_next.data_len    = i_in.rx_byte - LEN_MIN;
                    o_next.running_xor = i_state.running_xor ^ i_in.rx_byte;
                    o_next.position    = POS_DEST;
                end
            end else if (i_state.position == POS_DEST) begin
                o_res.kind              = KIND_DEST;
                o_res.frame_destination = i_in.rx_byte;
                o_next.held_destination = i_in.rx_byte;
                o_next.running_xor      = i_state.running_xor ^ i_in.rx_byte;
                o_next.position         = HDR_BYTES;
            end else if (data_pos < {1'b0, i_state.data_len}) begin
                o_res.kind         = KIND_DATA;
                o_res.data_index   = data_pos[7:0];
                o_next.running_xor = i_state.running_xor ^ i_in.rx_byte;
                o_next.position    = i_state.position + 9'd1;
            end else begin
                // Checksum byte closes the frame
                o_res.kind = (i_in.rx_byte == i_state.running_xor) ? KIND_GOOD : KIND_BAD;
                o_next     = '0;
            end
        end
    end

endmodule

// ===== sv/ibus_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_parser_core
// I-Bus frame deframer with XOR checksum: tags each received byte and closes
// each frame as good, bad or aborted.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//
//  One item per cycle while o_in_stall is low; each accepted item gives one
//  result in the result register, or in the skid register behind it while
//  the output is stalled, so input stays open for one more transfer. The
//  state update and result are a single step of logic ahead of the result
//  register. o_in_stall rises only when the skid register is full. Reset
//  clears the parser state and both output slots.
// ----------------------------------------------------------------------------
module ibus_frame_parser_core
    import ibfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state r_state;
    t_state n_state;
    t_out   step_res;
    t_out   r_out;
    t_out   r_skid;
    logic   r_out_valid;
    logic   r_skid_valid;
    logic   in_accept;
    logic   out_take;

    ibfp_step u_step (
        .i_state (r_state),
        .i_in    (i_in_data),
        .o_next  (n_state),
        .o_res   (step_res)
    );

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output and skid slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= step_res;
            end else begin
                r_skid <= step_res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output slot empty");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.func == FUNC_TIMEOUT) |=> (r_state.position == POS_SOURCE))
        else $error("timeout did not clear the parser");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.position <= ({1'b0, r_state.data_len} + HDR_BYTES))
        else $error("frame position beyond checksum byte");

    a_no_restart_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.restart_idle_timer) |->
            (r_out.kind == KIND_NONE || r_out.kind == KIND_ABORT))
        else $error("timeout result with a byte kind");

endmodule
